// ===== rtl/bwt_pkg.sv =====
`timescale 1ns / 1ps
package bwt_pkg;

   localparam int SYM_W  = 8;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 7;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] fill_idx;
      logic [SYM_W-1:0] load_sym;
      logic             clear;
      logic             step;
      logic             first;
      logic             last_step;
      logic [CNT_W-1:0] n;
      logic [IDX_W-1:0] ref_rot;
      logic [SYM_W-1:0] ref_sym;
   } cell_ctrl_type;

endpackage

// ===== rtl/bwt_cell.sv =====
`timescale 1ns / 1ps
module bwt_cell #(
   parameter int CELL_IDX = 0
) (
   input  logic                      clock,
   input  bwt_pkg::cell_ctrl_type    ctrl,
   input  logic [bwt_pkg::SYM_W-1:0] next_sym,
   input  logic [bwt_pkg::SYM_W-1:0] head_sym,
   output logic [bwt_pkg::SYM_W-1:0] sym,
   output logic [bwt_pkg::SYM_W-1:0] last_sym,
   output logic [bwt_pkg::IDX_W-1:0] rank
);

   localparam logic [bwt_pkg::CNT_W-1:0] MY_IDX = bwt_pkg::CNT_W'(CELL_IDX);

   logic [bwt_pkg::SYM_W-1:0] sym_ff, sym_in, last_ff, last_in;
   logic [bwt_pkg::IDX_W-1:0] rank_ff, rank_in;
   logic                      dec_ff, dec_in, gt_ff, gt_in;
   logic                      is_tail, dec_cur, gt_cur, r_lt_k;
   logic [bwt_pkg::CNT_W-1:0] rot_k;

   // rotation seen by this cell: cell c holds rotation (n - c) mod n
   assign is_tail = (MY_IDX == ctrl.n - 1'b1);
   assign rot_k   = (CELL_IDX == 0) ? '0 : ctrl.n - MY_IDX;
   assign r_lt_k  = {1'b0, ctrl.ref_rot} < rot_k;
   assign dec_cur = ctrl.first ? 1'b0 : dec_ff;
   assign gt_cur  = ctrl.first ? 1'b0 : gt_ff;

   // ring shift and symbol comparison against the reference rotation
   always_comb begin
      sym_in  = sym_ff;
      dec_in  = dec_ff;
      gt_in   = gt_ff;
      rank_in = rank_ff;
      last_in = last_ff;
      if (ctrl.load && (ctrl.fill_idx == bwt_pkg::IDX_W'(CELL_IDX))) begin
         sym_in = ctrl.load_sym;
      end
      if (ctrl.clear) begin
         rank_in = '0;
      end
      if (ctrl.step) begin
         sym_in = is_tail ? head_sym : next_sym;
         dec_in = dec_cur | (sym_ff != ctrl.ref_sym);
         gt_in  = dec_cur ? gt_cur : (sym_ff > ctrl.ref_sym);
         if (ctrl.last_step) begin
            last_in = sym_ff;
            if (gt_in || (!dec_in && r_lt_k)) begin
               rank_in = rank_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      dec_ff  <= dec_in;
      gt_ff   <= gt_in;
      rank_ff <= rank_in;
      last_ff <= last_in;
   end

   assign sym      = sym_ff;
   assign last_sym = last_ff;
   assign rank     = rank_ff;

endmodule

// ===== rtl/bwt_forward_block_core.sv =====
`timescale 1ns / 1ps
// channel   | ports                                          | transfer
// ----------+------------------------------------------------+-------------------------
// request   | start, busy, req_symbol_in, req_block_end      | start high and busy low
// response  | rsp_valid, rsp_symbol_out, rsp_primary_index,  | every cycle rsp_valid high
//           | rsp_run_end                                    |
// a symbol without block end is stored in the next free cell while the block is not
// full. a block of n symbols is ranked by a ring of cells in n passes, each cell
// comparing its rotation against the reference rotation in step; then n results follow.
// reset is synchronous and empties the block; busy is high from block end until the
// last result. the receiver cannot stall the result stream.
module bwt_forward_block_core #(
   parameter int BLOCK_MAX = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [bwt_pkg::SYM_W-1:0] req_symbol_in,
   input  logic                      req_block_end,
   output logic                      rsp_valid,
   output logic [bwt_pkg::SYM_W-1:0] rsp_symbol_out,
   output logic [bwt_pkg::IDX_W-1:0] rsp_primary_index,
   output logic                      rsp_run_end
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SORT = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;
   localparam logic [bwt_pkg::CNT_W-1:0] CAP = bwt_pkg::CNT_W'(BLOCK_MAX);

   logic [1:0]                state_ff, state_in;
   logic [bwt_pkg::CNT_W-1:0] fill_ff, fill_in, n_ff, n_in, fill_next;
   logic [bwt_pkg::IDX_W-1:0] m_ff, m_in, r_ff, r_in, i_ff, i_in, ref_ff, ref_in;
   logic                      accept, m_last, r_last, i_last;
   bwt_pkg::cell_ctrl_type    ctrl;

   logic [bwt_pkg::SYM_W-1:0] cell_sym  [BLOCK_MAX];
   logic [bwt_pkg::SYM_W-1:0] cell_last [BLOCK_MAX];
   logic [bwt_pkg::IDX_W-1:0] cell_rank [BLOCK_MAX];

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign fill_next = (fill_ff < CAP) ? fill_ff + 1'b1 : fill_ff;
   assign m_last    = ({1'b0, m_ff} == n_ff - 1'b1);
   assign r_last    = ({1'b0, r_ff} == n_ff - 1'b1);
   assign i_last    = ({1'b0, i_ff} == n_ff - 1'b1);

   // sequencer: load, ranking passes, result stream
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      n_in     = n_ff;
      m_in     = m_ff;
      r_in     = r_ff;
      i_in     = i_ff;
      ref_in   = ref_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in = fill_next;
               if (req_block_end) begin
                  fill_in  = '0;
                  n_in     = fill_next;
                  m_in     = '0;
                  r_in     = '0;
                  ref_in   = '0;
                  state_in = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            m_in = m_ff + 1'b1;
            if (m_last) begin
               m_in   = '0;
               r_in   = r_ff + 1'b1;
               ref_in = (ref_ff == '0) ? bwt_pkg::IDX_W'(n_ff - 1'b1) : ref_ff - 1'b1;
               if (r_last) begin
                  i_in     = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            i_in = i_ff + 1'b1;
            if (i_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
      end
      n_ff   <= n_in;
      m_ff   <= m_in;
      r_ff   <= r_in;
      i_ff   <= i_in;
      ref_ff <= ref_in;
   end

   // control broadcast to the cell row
   always_comb begin
      ctrl.load      = accept && (fill_ff < CAP);
      ctrl.fill_idx  = fill_ff[bwt_pkg::IDX_W-1:0];
      ctrl.load_sym  = req_symbol_in;
      ctrl.clear     = accept && req_block_end;
      ctrl.step      = (state_ff == ST_SORT);
      ctrl.first     = (m_ff == '0);
      ctrl.last_step = m_last;
      ctrl.n         = n_ff;
      ctrl.ref_rot   = r_ff;
      ctrl.ref_sym   = cell_sym[ref_ff];
   end

   // row of cells forming the rotation ring
   for (genvar c = 0; c < BLOCK_MAX; c++) begin : g_cell
      bwt_cell #(.CELL_IDX(c)) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .next_sym (cell_sym[(c + 1) % BLOCK_MAX]),
         .head_sym (cell_sym[0]),
         .sym      (cell_sym[c]),
         .last_sym (cell_last[c]),
         .rank     (cell_rank[c])
      );
   end

   // pick the cell whose rank equals the output position
   always_comb begin
      rsp_symbol_out = '0;
      for (int c = 0; c < BLOCK_MAX; c++) begin
         if ((bwt_pkg::CNT_W'(c) < n_ff) && (cell_rank[c] == i_ff)) begin
            rsp_symbol_out = rsp_symbol_out | cell_last[c];
         end
      end
   end

   assign rsp_valid         = (state_ff == ST_OUT);
   assign rsp_primary_index = cell_rank[0];
   assign rsp_run_end       = i_last;

endmodule
